// File: hw/rtl/ntm_pkg.sv
package ntm_pkg;

  // sizes of the sample window and the thermistor table
  localparam int unsigned WINDOW        = 100;
  localparam int unsigned TABLE_ENTRIES = 141;
  localparam int unsigned TABLE_OFFSET  = 10;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned PTR_W    = $clog2(WINDOW);
  localparam int unsigned SUM_W    = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int unsigned IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int unsigned TEMP_W   = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OPEN_W   = 13;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned REM_W    = SAMPLE_W + 4;

  // average by reciprocal multiply: floor(sum / WINDOW) = (sum * DIV_MUL) >> DIV_SHIFT
  localparam int unsigned DIV_SHIFT = 26;
  localparam longint unsigned DIV_MUL =
    ((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned MUL_W  = $clog2(DIV_MUL + 1);
  localparam int unsigned PROD_W = SUM_W + MUL_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

  localparam logic [SAMPLE_W-1:0] SHORT_RST  = 12'd15;
  localparam logic [OPEN_W-1:0]   OPEN_RST   = 13'd4096;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd100;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 3'd0,
    STATUS_SHORT = 3'd1,
    STATUS_OPEN  = 3'd2,
    STATUS_BELOW = 3'd3,
    STATUS_ABOVE = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    status_e                  status;
  } conv_res_t;

  typedef enum logic [1:0] {ST_IDLE, ST_FILT, ST_CONV, ST_DONE} top_state_e;
  typedef enum logic [1:0] {F_IDLE, F_RMW, F_MUL, F_DONE} filt_state_e;
  typedef enum logic [2:0] {C_IDLE, C_SEARCH, C_MATCH, C_DIV, C_DONE} conv_state_e;

  // adc code per degree, -10 .. 130 degrees
  localparam logic [SAMPLE_W-1:0] NTC_ROM [TABLE_ENTRIES] = '{
    12'd160,  12'd170,  12'd180,  12'd189,  12'd200,  12'd210,  12'd221,  12'd233,
    12'd245,  12'd258,  12'd271,  12'd284,  12'd298,  12'd313,  12'd328,  12'd344,
    12'd361,  12'd372,  12'd396,  12'd416,  12'd440,  12'd462,  12'd482,  12'd508,
    12'd528,  12'd558,  12'd576,  12'd600,  12'd632,  12'd654,  12'd682,  12'd710,
    12'd734,  12'd758,  12'd794,  12'd826,  12'd860,  12'd892,  12'd917,  12'd950,
    12'd982,  12'd1014, 12'd1044, 12'd1075, 12'd1107, 12'd1146, 12'd1182, 12'd1220,
    12'd1260, 12'd1294, 12'd1331, 12'd1372, 12'd1405, 12'd1454, 12'd1497, 12'd1556,
    12'd1598, 12'd1632, 12'd1672, 12'd1720, 12'd1760, 12'd1804, 12'd1842, 12'd1882,
    12'd1920, 12'd1958, 12'd2010, 12'd2079, 12'd2122, 12'd2158, 12'd2193, 12'd2233,
    12'd2272, 12'd2316, 12'd2347, 12'd2380, 12'd2412, 12'd2446, 12'd2475, 12'd2506,
    12'd2539, 12'd2574, 12'd2608, 12'd2638, 12'd2664, 12'd2698, 12'd2726, 12'd2760,
    12'd2784, 12'd2812, 12'd2842, 12'd2870, 12'd2900, 12'd2924, 12'd2952, 12'd2976,
    12'd2996, 12'd3022, 12'd3042, 12'd3064, 12'd3092, 12'd3112, 12'd3132, 12'd3154,
    12'd3176, 12'd3196, 12'd3214, 12'd3234, 12'd3250, 12'd3269, 12'd3292, 12'd3338,
    12'd3354, 12'd3374, 12'd3384, 12'd3392, 12'd3409, 12'd3426, 12'd3442, 12'd3458,
    12'd3473, 12'd3489, 12'd3503, 12'd3518, 12'd3532, 12'd3545, 12'd3559, 12'd3572,
    12'd3585, 12'd3597, 12'd3609, 12'd3621, 12'd3632, 12'd3643, 12'd3654, 12'd3665,
    12'd3675, 12'd3685, 12'd3695, 12'd3705, 12'd3714
  };

  // temperature in tenths at a table index
  function automatic logic signed [TEMP_W-1:0] temp_base(input logic [IDX_W-1:0] idx);
    logic [TEMP_W-1:0] r;
    r = TEMP_W'(idx) * TEMP_W'(10) - TEMP_W'(TABLE_OFFSET * 10);
    return signed'(r);
  endfunction

endpackage

// File: hw/rtl/ntc_temperature_monitor_top.sv
// Thermistor temperature monitor. Each item carries one 12-bit adc sample; each
// produces one result with the window average (or the first ring entry until the
// last slot holds a nonzero sample), a flag for a new conversion, and the held
// temperature in tenths of a degree with its status (0 ok, 1 short, 2 open,
// 3 below table, 4 above table; the temperature reads 0 on a fault). Every
// update_period samples the average is converted by a binary search of the
// -10 .. 130 degree table and linear interpolation. One item is worked on at a
// time, in steps set by the ring memory's read-modify-write, the reciprocal
// multiply for the average, one table probe per cycle (up to 8 probes) and a
// 4-step divide. The next item is accepted while a finished result waits in
// the output register. No clearing pass is needed after reset. The user must
// write configuration only while no item is in flight; the block does not
// enforce this itself.
module ntc_temperature_monitor_top import ntm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_W-1:0]         adc_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [SAMPLE_W-1:0]         filtered_adc_o,
  output logic                        temp_updated_o,
  output logic signed [TEMP_W-1:0]    temperature_tenths_o,
  output logic [STATUS_W-1:0]         temp_status_o
);

  top_state_e state_q, state_d;

  logic [SAMPLE_W-1:0]      short_q;
  logic [OPEN_W-1:0]        open_q;
  logic [PERIOD_W-1:0]      period_q, period_eff, pc_q, pc_next;
  logic [SAMPLE_W-1:0]      filt_q;
  logic                     upd_q;
  logic signed [TEMP_W-1:0] held_temp_q;
  status_e                  held_status_q;
  logic                     out_valid_q, out_upd_q;
  logic [SAMPLE_W-1:0]      out_filt_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  logic [STATUS_W-1:0]      out_status_q;

  logic                     in_accept, conv_due, out_load;
  logic                     filt_done, conv_start, conv_done;
  logic [SAMPLE_W-1:0]      filt_val;
  conv_res_t                conv_res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign pc_next    = pc_q + PERIOD_W'(1);
  assign conv_due   = (pc_next >= period_eff);
  assign conv_start = (state_q == ST_FILT) && filt_done && conv_due;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  ntm_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_accept),
    .sample_i (adc_sample_i),
    .done_o   (filt_done),
    .filt_o   (filt_val)
  );

  ntm_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (conv_start),
    .value_i     (filt_val),
    .short_thr_i (short_q),
    .open_thr_i  (open_q),
    .done_o      (conv_done),
    .res_o       (conv_res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q  <= SHORT_RST;
      open_q   <= OPEN_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHORT:  short_q  <= cfg_data_i[SAMPLE_W-1:0];
        CFG_OPEN:   open_q   <= cfg_data_i[OPEN_W-1:0];
        CFG_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (filt_done) begin
          state_d = conv_due ? ST_CONV : ST_DONE;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // period counter and held conversion result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= '0;
      held_temp_q   <= '0;
      held_status_q <= STATUS_OK;
    end else begin
      if (state_q == ST_FILT && filt_done) begin
        pc_q <= conv_due ? '0 : pc_next;
      end
      if (state_q == ST_CONV && conv_done) begin
        held_temp_q   <= conv_res.temp;
        held_status_q <= conv_res.status;
      end
    end
  end

  // per-item working values
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILT && filt_done) begin
      filt_q <= filt_val;
      upd_q  <= conv_due;
    end
  end

  // output register, free to reload once the waiting item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_filt_q   <= filt_q;
      out_upd_q    <= upd_q;
      out_temp_q   <= held_temp_q;
      out_status_q <= held_status_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign filtered_adc_o       = out_filt_q;
  assign temp_updated_o       = out_upd_q;
  assign temperature_tenths_o = out_temp_q;
  assign temp_status_o        = out_status_q;

endmodule

// File: hw/rtl/ntm_filter.sv
module ntm_filter import ntm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                done_o,
  output logic [SAMPLE_W-1:0] filt_o
);

  filt_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [PTR_W-1:0]    wp_q;
  logic                filled_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] ring_first_q, ring_last_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] avg;
  logic                rd_en, wr_en, wp_last;

  assign rd_en   = (state_q == F_IDLE) && start_i;
  assign wr_en   = (state_q == F_RMW);
  assign wp_last = (wp_q == PTR_W'(WINDOW - 1));

  // ring memory, read in the accept cycle and written in the cycle after at the same slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wp_q] <= sample_q;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[wp_q];
    end
  end

  // slots not yet written since reset read as zero
  assign old_sample = filled_q ? rd_data_q : '0;
  assign sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          state_d = F_RMW;
        end
      end
      F_RMW:  state_d = F_MUL;
      F_MUL:  state_d = F_DONE;
      F_DONE: begin
        done_o  = 1'b1;
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // window state: pointer, fill flag, running sum, first and last slot copies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      filled_q     <= 1'b0;
      sum_q        <= '0;
      ring_first_q <= '0;
      ring_last_q  <= '0;
    end else if (wr_en) begin
      sum_q <= sum_d;
      if (wp_q == '0) begin
        ring_first_q <= sample_q;
      end
      if (wp_last) begin
        ring_last_q <= sample_q;
        wp_q        <= '0;
        filled_q    <= 1'b1;
      end else begin
        wp_q <= wp_q + PTR_W'(1);
      end
    end
  end

  // sample capture and reciprocal product
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      sample_q <= sample_i;
    end
    if (state_q == F_MUL) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(DIV_MUL);
    end
  end

  assign avg    = prod_q[DIV_SHIFT +: SAMPLE_W];
  assign filt_o = (ring_last_q != '0) ? avg : ring_first_q;

endmodule

// File: hw/rtl/ntm_convert.sv
module ntm_convert import ntm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] value_i,
  input  logic [SAMPLE_W-1:0] short_thr_i,
  input  logic [OPEN_W-1:0]   open_thr_i,
  output logic                done_o,
  output conv_res_t           res_o
);

  conv_state_e state_q, state_d;

  logic [SAMPLE_W-1:0]      v_q;
  logic [IDX_W-1:0]         lo_q, hi_q, mid;
  logic [IDX_W:0]           mid_sum;
  logic [REM_W-1:0]         rem_q, den_sh;
  logic [SAMPLE_W-1:0]      den_q;
  logic [3:0]               quo_q, quo_nx;
  logic [1:0]               bit_q;
  logic signed [TEMP_W-1:0] base_q;
  conv_res_t                res_q;
  logic [SAMPLE_W-1:0]      rom_lo, rom_hi, rom_mid;
  logic                     is_short, is_open, is_below, is_above, is_fault;
  logic                     span_gt1, go_lo, need_div, trial_ok;

  // fault checks on the incoming value
  assign is_short = (value_i <= short_thr_i);
  assign is_open  = ({1'b0, value_i} >= open_thr_i);
  assign is_below = (value_i < NTC_ROM[0]);
  assign is_above = (value_i > NTC_ROM[TABLE_ENTRIES - 1]);
  assign is_fault = is_short || is_open || is_below || is_above;

  // one table probe per cycle
  assign mid_sum  = (IDX_W + 1)'(lo_q) + (IDX_W + 1)'(hi_q);
  assign mid      = mid_sum[IDX_W:1];
  assign rom_lo   = NTC_ROM[lo_q];
  assign rom_hi   = NTC_ROM[hi_q];
  assign rom_mid  = NTC_ROM[mid];
  assign span_gt1 = ((hi_q - lo_q) > IDX_W'(1));
  assign go_lo    = (v_q <= rom_hi) && (v_q > rom_mid);
  assign need_div = (rom_lo != v_q) && (rom_hi != v_q) && (rom_hi > rom_lo);

  // restoring divide step, quotient below ten
  assign den_sh   = REM_W'(den_q) << bit_q;
  assign trial_ok = (rem_q >= den_sh);
  always_comb begin
    quo_nx = quo_q;
    if (trial_ok) begin
      quo_nx[bit_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          state_d = is_fault ? C_DONE : C_SEARCH;
        end
      end
      C_SEARCH: begin
        if (!span_gt1) begin
          state_d = C_MATCH;
        end
      end
      C_MATCH: state_d = need_div ? C_DIV : C_DONE;
      C_DIV: begin
        if (bit_q == 2'd0) begin
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        done_o  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  // search, interpolation and result datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        v_q  <= value_i;
        lo_q <= '0;
        hi_q <= IDX_W'(TABLE_ENTRIES - 1);
        res_q.temp <= '0;
        if (is_short) begin
          res_q.status <= STATUS_SHORT;
        end else if (is_open) begin
          res_q.status <= STATUS_OPEN;
        end else if (is_below) begin
          res_q.status <= STATUS_BELOW;
        end else begin
          res_q.status <= STATUS_ABOVE;
        end
      end
      C_SEARCH: begin
        if (span_gt1) begin
          if (go_lo) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid;
          end
        end
      end
      C_MATCH: begin
        res_q.status <= STATUS_OK;
        if (rom_hi == v_q && rom_lo != v_q) begin
          res_q.temp <= temp_base(hi_q);
        end else begin
          res_q.temp <= temp_base(lo_q);
        end
        // (d * 100 + 5) / 10 equals d * 10
        rem_q  <= REM_W'(v_q - rom_lo) * REM_W'(10);
        den_q  <= rom_hi - rom_lo;
        quo_q  <= '0;
        bit_q  <= 2'd3;
        base_q <= temp_base(lo_q);
      end
      C_DIV: begin
        if (trial_ok) begin
          rem_q <= rem_q - den_sh;
        end
        quo_q <= quo_nx;
        bit_q <= bit_q - 2'd1;
        if (bit_q == 2'd0) begin
          res_q.temp <= base_q + TEMP_W'(quo_nx);
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule

// File: hw/rtl/ntm_checker.sv
module ntm_checker import ntm_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [SAMPLE_W-1:0]      filtered_adc_o,
  input logic                     temp_updated_o,
  input logic signed [TEMP_W-1:0] temperature_tenths_o,
  input logic [STATUS_W-1:0]      temp_status_o
);

  // an accepted item keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_adc_o)
      && $stable(temp_updated_o) && $stable(temperature_tenths_o)
      && $stable(temp_status_o))
    else $error("stalled result changed");

  // status code stays in its defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temp_status_o <= STATUS_W'(STATUS_ABOVE))
    else $error("undefined status code");

  // a fault reports zero temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && temp_status_o != STATUS_W'(STATUS_OK) |-> temperature_tenths_o == '0)
    else $error("fault with nonzero temperature");

  // a good conversion stays within the table range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && temp_status_o == STATUS_W'(STATUS_OK)
      |-> temperature_tenths_o >= -12'sd100 && temperature_tenths_o <= 12'sd1300)
    else $error("temperature outside table range");

endmodule

bind ntc_temperature_monitor_top ntm_checker u_ntm_checker (.*);

// File: verif/ntc_temperature_monitor_top_tb.sv
module ntc_temperature_monitor_top_tb import ntm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1250;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned MAX_REPORTS = 30;

  // adc code per degree, -10 .. 130 degrees
  localparam int unsigned THERM_CODE [TABLE_ENTRIES] = '{
    160, 170, 180, 189, 200, 210, 221, 233, 245, 258,
    271, 284, 298, 313, 328, 344, 361, 372, 396, 416,
    440, 462, 482, 508, 528, 558, 576, 600, 632, 654,
    682, 710, 734, 758, 794, 826, 860, 892, 917, 950,
    982, 1014, 1044, 1075, 1107, 1146, 1182, 1220, 1260, 1294,
    1331, 1372, 1405, 1454, 1497, 1556, 1598, 1632, 1672, 1720,
    1760, 1804, 1842, 1882, 1920, 1958, 2010, 2079, 2122, 2158,
    2193, 2233, 2272, 2316, 2347, 2380, 2412, 2446, 2475, 2506,
    2539, 2574, 2608, 2638, 2664, 2698, 2726, 2760, 2784, 2812,
    2842, 2870, 2900, 2924, 2952, 2976, 2996, 3022, 3042, 3064,
    3092, 3112, 3132, 3154, 3176, 3196, 3214, 3234, 3250, 3269,
    3292, 3338, 3354, 3374, 3384, 3392, 3409, 3426, 3442, 3458,
    3473, 3489, 3503, 3518, 3532, 3545, 3559, 3572, 3585, 3597,
    3609, 3621, 3632, 3643, 3654, 3665, 3675, 3685, 3695, 3705,
    3714
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0]      filt;
    logic                     upd;
    logic signed [TEMP_W-1:0] temp;
    logic [STATUS_W-1:0]      status;
  } monitor_result_t;

  // dut signals
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i  = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [SAMPLE_W-1:0]      adc_sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]      filtered_adc_o;
  logic                     temp_updated_o;
  logic signed [TEMP_W-1:0] temperature_tenths_o;
  logic [STATUS_W-1:0]      temp_status_o;

  // predictor state and register copies
  logic [SAMPLE_W-1:0]      sample_hist [WINDOW] = '{default: '0};
  int unsigned              hist_sum     = 0;
  int unsigned              hist_wr_ptr  = 0;
  logic [PERIOD_W-1:0]      conv_count   = '0;
  logic signed [TEMP_W-1:0] held_temp    = '0;
  status_e                  held_status  = STATUS_OK;
  logic [SAMPLE_W-1:0]      reg_short    = SHORT_RST;
  logic [OPEN_W-1:0]        reg_open     = OPEN_RST;
  logic [PERIOD_W-1:0]      reg_period   = PERIOD_RST;

  monitor_result_t pending_results [$];
  int unsigned     items_sent     = 0;
  int unsigned     results_seen   = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     idle_cycles    = 0;
  bit              tx_steady      = 1'b0;
  bit              rx_steady      = 1'b0;
  bit              hold_request   = 1'b0;
  int unsigned     hold_cycles    = 0;

  ntc_temperature_monitor_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .adc_sample_i        (adc_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .filtered_adc_o      (filtered_adc_o),
    .temp_updated_o      (temp_updated_o),
    .temperature_tenths_o(temperature_tenths_o),
    .temp_status_o       (temp_status_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL ntc_temperature_monitor_top");
      $finish;
    end
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, msg);
    end
  endtask

  // table lookup with fault checks, updates the held temperature and status
  function automatic void convert_average(input int unsigned v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned span;
    int          t;
    if (v <= reg_short) begin
      held_status = STATUS_SHORT;
      held_temp   = '0;
      return;
    end
    if (v >= reg_open) begin
      held_status = STATUS_OPEN;
      held_temp   = '0;
      return;
    end
    if (v < THERM_CODE[0]) begin
      held_status = STATUS_BELOW;
      held_temp   = '0;
      return;
    end
    if (v > THERM_CODE[TABLE_ENTRIES-1]) begin
      held_status = STATUS_ABOVE;
      held_temp   = '0;
      return;
    end
    lo = 0;
    hi = TABLE_ENTRIES - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (v <= THERM_CODE[hi] && v > THERM_CODE[mid]) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    if (THERM_CODE[lo] == v) begin
      t = (int'(lo) - int'(TABLE_OFFSET)) * 10;
    end else if (THERM_CODE[hi] == v) begin
      t = (int'(hi) - int'(TABLE_OFFSET)) * 10;
    end else if (THERM_CODE[hi] <= THERM_CODE[lo]) begin
      t = (int'(lo) - int'(TABLE_OFFSET)) * 10;
    end else begin
      span = THERM_CODE[hi] - THERM_CODE[lo];
      t = (int'(lo) - int'(TABLE_OFFSET)) * 10
          + int'((((v - THERM_CODE[lo]) * 100 + 5) / 10) / span);
    end
    held_status = STATUS_OK;
    held_temp   = TEMP_W'(t);
  endfunction

  // one sample into the window, returns the result it causes
  function automatic monitor_result_t predict_monitor(input logic [SAMPLE_W-1:0] sample);
    monitor_result_t r;
    int unsigned     period;
    int unsigned     filt;
    period = (reg_period == 0) ? 1 : int'(reg_period);
    hist_sum = hist_sum - sample_hist[hist_wr_ptr] + sample;
    sample_hist[hist_wr_ptr] = sample;
    hist_wr_ptr = (hist_wr_ptr + 1 >= WINDOW) ? 0 : hist_wr_ptr + 1;
    // window counts as filled only once its last slot is nonzero
    if (sample_hist[WINDOW-1] == 0) begin
      filt = sample_hist[0];
    end else begin
      filt = hist_sum / WINDOW;
    end
    conv_count = conv_count + 1'b1;
    r.upd = 1'b0;
    if (conv_count >= period) begin
      convert_average(filt);
      conv_count = '0;
      r.upd = 1'b1;
    end
    r.filt   = SAMPLE_W'(filt);
    r.temp   = held_temp;
    r.status = held_status;
    return r;
  endfunction

  // offer one item after a random gap, predict once it is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(predict_monitor(sample));
    items_sent++;
  endtask

  // stop offering and wait for every pending result
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // write all three registers while the block is idle
  task automatic apply_settings(input logic [SAMPLE_W-1:0] short_thr,
                                input logic [OPEN_W-1:0]   open_thr,
                                input logic [PERIOD_W-1:0] period);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_SHORT;
    cfg_data_i  <= CFG_DATA_W'(short_thr);
    @(posedge clk_i);
    cfg_index_i <= CFG_OPEN;
    cfg_data_i  <= CFG_DATA_W'(open_thr);
    @(posedge clk_i);
    cfg_index_i <= CFG_PERIOD;
    cfg_data_i  <= CFG_DATA_W'(period);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_short  = short_thr;
    reg_open   = open_thr;
    reg_period = period;
  endtask

  // result side: random stalls, optional long hold, field compare
  initial begin : result_checker
    int unsigned     pause;
    monitor_result_t want;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      pause = rx_steady ? 0 : $urandom_range(0, 18);
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_results.size() == 0) begin
        log_mismatch("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        if (filtered_adc_o !== want.filt)
          log_mismatch($sformatf("filtered_adc got %0d want %0d", filtered_adc_o, want.filt));
        if (temp_updated_o !== want.upd)
          log_mismatch($sformatf("temp_updated got %0b want %0b", temp_updated_o, want.upd));
        if (temperature_tenths_o !== want.temp)
          log_mismatch($sformatf("temperature_tenths got %0d want %0d",
                                 temperature_tenths_o, want.temp));
        if (temp_status_o !== want.status)
          log_mismatch($sformatf("temp_status got %0d want %0d", temp_status_o, want.status));
      end
      results_seen++;
    end
  end

  // first entry is reported before fill; thresholds and periods at their extremes
  task automatic test_first_entry();
    send_sample(12'd160);
    send_sample(12'd4095);
    apply_settings(SHORT_RST, OPEN_RST, 10'd1);
    send_sample(12'd0);
    send_sample(12'd2048);
    apply_settings(12'd160, OPEN_RST, 10'd1);
    send_sample(12'd1365);
    apply_settings(12'd0, 13'd160, 10'd1);
    send_sample(12'd2730);
    apply_settings(12'd159, 13'd161, 10'd1);
    send_sample(12'd4095);
    apply_settings(12'd4095, 13'd0, 10'd1);
    send_sample(12'd1);
    apply_settings(12'd0, 13'd0, 10'd1);
    send_sample(12'd3714);
    // period zero converts on every item
    apply_settings(12'd0, OPEN_RST, 10'd0);
    send_sample(12'd4094);
    send_sample(12'd3);
    apply_settings(SHORT_RST, OPEN_RST, 10'd1023);
    send_sample(12'd2047);
    send_sample(12'd2);
    apply_settings(SHORT_RST, OPEN_RST, 10'd2);
    send_sample(12'd1024);
    send_sample(12'd512);
  endtask

  // a genuine zero in the last slot keeps the first entry reported
  task automatic test_zero_last_slot();
    int unsigned level;
    while (hist_wr_ptr != WINDOW - 1) send_sample(12'($urandom_range(1, 4095)));
    send_sample(12'd0);
    repeat (20) send_sample(12'($urandom_range(0, 4095)));
    level = $urandom_range(THERM_CODE[20], THERM_CODE[120]);
    while (hist_wr_ptr != 0) send_sample(SAMPLE_W'(level + $urandom_range(0, 4)));
    repeat (10) send_sample(SAMPLE_W'(level + $urandom_range(0, 4)));
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_output_backpressure();
    hold_cycles  = 400;
    hold_request = 1'b1;
    tx_steady    = 1'b1;
    repeat (40) send_sample(12'($urandom_range(0, 4095)));
    tx_steady    = 1'b0;
  endtask

  // runs of a level with jitter and some noise, settings change between runs
  task automatic test_random_levels();
    int unsigned         run_len;
    int unsigned         k;
    int unsigned         level;
    int                  v;
    logic [SAMPLE_W-1:0] short_thr;
    logic [OPEN_W-1:0]   open_thr;
    logic [PERIOD_W-1:0] period;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 15))
          0:       short_thr = 12'd0;
          1:       short_thr = 12'd4095;
          2, 3, 4: short_thr = 12'($urandom_range(0, 300));
          default: short_thr = SHORT_RST;
        endcase
        case ($urandom_range(0, 15))
          0:       open_thr = 13'd0;
          1, 2, 3: open_thr = 13'($urandom_range(2500, 4096));
          default: open_thr = OPEN_RST;
        endcase
        case ($urandom_range(0, 11))
          0:       period = 10'd0;
          1:       period = 10'd1023;
          2, 3:    period = 10'($urandom_range(9, 200));
          default: period = 10'($urandom_range(1, 8));
        endcase
        apply_settings(short_thr, open_thr, period);
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      // pick the level the window settles toward
      case ($urandom_range(0, 7))
        0: level = THERM_CODE[$urandom_range(0, TABLE_ENTRIES - 1)];
        1: begin
          k = $urandom_range(0, TABLE_ENTRIES - 2);
          level = $urandom_range(THERM_CODE[k], THERM_CODE[k+1]);
        end
        2: level = $urandom_range(100, 159);
        3: level = $urandom_range(3715, 4095);
        4: level = 0;
        5: level = $urandom_range(0, 30);
        default: level = $urandom_range(0, 4095);
      endcase
      run_len = $urandom_range(10, 120);
      repeat (run_len) begin
        if ($urandom_range(0, 7) == 0) begin
          send_sample(12'($urandom_range(0, 4095)));
        end else begin
          v = int'(level) + int'($urandom_range(0, 6)) - 3;
          if (v < 0) v = 0;
          if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
          send_sample(SAMPLE_W'(v));
        end
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_entry();
    test_zero_last_slot();
    test_output_backpressure();
    test_random_levels();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS ntc_temperature_monitor_top");
    end else begin
      $display("FAIL ntc_temperature_monitor_top");
    end
    $finish;
  end

endmodule
